[hdl/chsc_pkg.sv]
// chsc_pkg: shared types, constants and register codes for the clock hand stepper controller.
// No dependencies; used by every module under hdl.
`default_nettype none

package chsc_pkg;

	localparam int MAX_PHASES = 8;
	localparam int PHASE_W    = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
	localparam int NIBBLE_W   = 4;

	localparam int REV_W      = 16;
	localparam int SPS_W      = 24;
	localparam int PATTERN_W  = 32;
	localparam int PCNT_W     = 4;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam int MIN_W      = 6;
	localparam int SEC_W      = 6;
	localparam int BTN_W      = 4;
	localparam int SPD_W      = 2;

	localparam int TSEC_W     = 12;   // minute*60+second, up to 3843
	localparam int FRAC_W     = 16;
	localparam int PROD_W     = TSEC_W + SPS_W;
	localparam int TARGET_W   = PROD_W - FRAC_W;
	localparam int DIFF_W     = TARGET_W + 1;
	localparam int POS_W      = TARGET_W + 1;
	localparam int PEND_W     = 17;
	localparam int SUM_W      = DIFF_W + 1;

	localparam int SECS_PER_MIN = 60;
	localparam int PEND_LIMIT   = 65535;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_REV_STEPS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_S = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_COUNT = 2'd3;

	localparam logic [REV_W-1:0]     RST_REV_STEPS   = 16'd4096;
	localparam logic [SPS_W-1:0]     RST_STEPS_PER_S = 24'd74565;
	localparam logic [PATTERN_W-1:0] RST_PATTERN     = 32'd839922192;
	localparam logic [PCNT_W-1:0]    RST_PHASE_COUNT = 4'd8;

	localparam logic OP_INIT = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	localparam logic [BTN_W-1:0] BTN_FWD_FAST = 4'b1000;
	localparam logic [BTN_W-1:0] BTN_FWD_SLOW = 4'b0100;
	localparam logic [BTN_W-1:0] BTN_REV_SLOW = 4'b0010;
	localparam logic [BTN_W-1:0] BTN_REV_FAST = 4'b0001;

	localparam logic [SPD_W-1:0] SPD_NORMAL = 2'd0;
	localparam logic [SPD_W-1:0] SPD_SLOW   = 2'd1;
	localparam logic [SPD_W-1:0] SPD_FAST   = 2'd2;

	typedef enum logic [1:0] {
		STEP_OFF,
		STEP_CW,
		STEP_CCW
	} step_t;

	typedef struct packed {
		logic             opcode;
		logic [MIN_W-1:0] minute;
		logic [SEC_W-1:0] second;
		logic             dst_now;
		logic             check_due;
		logic             move_due;
		logic [BTN_W-1:0] buttons;
	} item_t;

	typedef struct packed {
		logic [NIBBLE_W-1:0] coils;
		logic                direction;
		logic                motor_off;
		logic [SPD_W-1:0]    speed_class;
		logic                last;
	} result_t;

	typedef struct packed {
		logic [REV_W-1:0]     rev_steps;
		logic [SPS_W-1:0]     steps_per_s;
		logic [PATTERN_W-1:0] pattern;
		logic [PCNT_W-1:0]    phase_count;
	} cfg_t;

	// what the back end has to play for one loop pass
	typedef struct packed {
		step_t            s1;
		logic             has2;
		step_t            s2;
		logic [SPD_W-1:0] spd2;
	} plan_t;

endpackage

`default_nettype wire

[hdl/chsc_front.sv]
// chsc_front: takes loop requests, tracks hand position, pending steps and DST state,
// and turns each pass into a step plan. Depends on chsc_pkg.
`default_nettype none

module chsc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire chsc_pkg::cfg_t  cfg,
	input  wire chsc_pkg::item_t item,
	input  wire logic            item_valid,
	output logic                 item_stall,
	output chsc_pkg::plan_t      plan,
	output logic                 push,
	input  wire logic            full
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIFF,
		S_FIX,
		S_MOVE,
		S_STEP1,
		S_BTN,
		S_STEP2
	} state_t;

	localparam logic signed [chsc_pkg::SUM_W-1:0] SUM_HI =
		chsc_pkg::SUM_W'(chsc_pkg::PEND_LIMIT);
	localparam logic signed [chsc_pkg::SUM_W-1:0] SUM_LO = -SUM_HI;
	localparam logic signed [chsc_pkg::SUM_W-1:0] SUM_ONE = chsc_pkg::SUM_W'(1);

	state_t state_q;

	logic            valid_s1;
	chsc_pkg::item_t item_s1;
	chsc_pkg::item_t work_q;

	logic        [chsc_pkg::TARGET_W-1:0] target_q;
	logic signed [chsc_pkg::DIFF_W-1:0]   diff_q;
	logic        [chsc_pkg::POS_W-1:0]    pos_q;
	logic        [chsc_pkg::REV_W-1:0]    hand_q;
	logic signed [chsc_pkg::PEND_W-1:0]   pend_q;
	logic                                 dst_q;
	chsc_pkg::step_t                      s1_kind_q;

	logic                                 take;
	logic [chsc_pkg::TSEC_W-1:0]          tsec;
	logic [chsc_pkg::PROD_W-1:0]          product;
	logic                                 in_init;
	logic                                 dst_flip;
	logic                                 w_init;
	logic                                 check_eff;
	logic                                 move_eff;
	logic [chsc_pkg::POS_W-1:0]           rev_pos;
	logic [chsc_pkg::POS_W-1:0]           pos_wrapped;
	logic signed [chsc_pkg::SUM_W-1:0]    rev_sum;
	logic signed [chsc_pkg::SUM_W-1:0]    addend;
	logic signed [chsc_pkg::SUM_W-1:0]    sum;
	logic signed [chsc_pkg::PEND_W-1:0]   pend_sat;
	chsc_pkg::step_t                      step_now;
	logic                                 btn_hit;
	logic                                 btn_up;
	logic [chsc_pkg::SPD_W-1:0]           btn_spd;

	// one request buffered ahead of the sequencer
	assign take       = (state_q == S_IDLE) && valid_s1;
	assign item_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	assign tsec = chsc_pkg::TSEC_W'(item_s1.minute) * chsc_pkg::TSEC_W'(chsc_pkg::SECS_PER_MIN)
		+ chsc_pkg::TSEC_W'(item_s1.second);
	assign product = chsc_pkg::PROD_W'(tsec) * chsc_pkg::PROD_W'(cfg.steps_per_s);

	assign in_init  = (item_s1.opcode == chsc_pkg::OP_INIT);
	assign dst_flip = !in_init && item_s1.check_due && (item_s1.dst_now != dst_q);

	assign w_init    = (work_q.opcode == chsc_pkg::OP_INIT);
	assign check_eff = w_init || work_q.check_due;
	assign move_eff  = w_init || work_q.move_due;

	assign rev_pos     = chsc_pkg::POS_W'(cfg.rev_steps);
	assign pos_wrapped = (pos_q >= rev_pos) ? (pos_q - rev_pos) : pos_q;
	assign rev_sum     = $signed({{(chsc_pkg::SUM_W - chsc_pkg::REV_W){1'b0}}, cfg.rev_steps});

	always_comb begin
		if (pend_q > 0) begin
			step_now = chsc_pkg::STEP_CW;
		end else if (pend_q < 0) begin
			step_now = chsc_pkg::STEP_CCW;
		end else begin
			step_now = chsc_pkg::STEP_OFF;
		end
	end

	always_comb begin
		unique case (work_q.buttons)
			chsc_pkg::BTN_FWD_FAST: begin
				btn_hit = 1'b1; btn_up = 1'b1; btn_spd = chsc_pkg::SPD_FAST;
			end
			chsc_pkg::BTN_FWD_SLOW: begin
				btn_hit = 1'b1; btn_up = 1'b1; btn_spd = chsc_pkg::SPD_SLOW;
			end
			chsc_pkg::BTN_REV_SLOW: begin
				btn_hit = 1'b1; btn_up = 1'b0; btn_spd = chsc_pkg::SPD_SLOW;
			end
			chsc_pkg::BTN_REV_FAST: begin
				btn_hit = 1'b1; btn_up = 1'b0; btn_spd = chsc_pkg::SPD_FAST;
			end
			default: begin
				btn_hit = 1'b0; btn_up = 1'b0; btn_spd = chsc_pkg::SPD_NORMAL;
			end
		endcase
	end

	// shared saturating adder for every change to the pending count
	always_comb begin
		unique case (state_q)
			S_IDLE: begin
				if (dst_flip) begin
					addend = item_s1.dst_now ? rev_sum : -rev_sum;
				end else begin
					addend = '0;
				end
			end
			S_MOVE: begin
				addend = $signed({diff_q[chsc_pkg::DIFF_W-1], diff_q});
			end
			S_BTN: begin
				addend = btn_up ? SUM_ONE : -SUM_ONE;
			end
			S_STEP1, S_STEP2: begin
				unique case (step_now)
					chsc_pkg::STEP_CW:  addend = -SUM_ONE;
					chsc_pkg::STEP_CCW: addend = SUM_ONE;
					default:            addend = '0;
				endcase
			end
			default: begin
				addend = '0;
			end
		endcase
	end

	assign sum = $signed({{(chsc_pkg::SUM_W - chsc_pkg::PEND_W){pend_q[chsc_pkg::PEND_W-1]}},
		pend_q}) + addend;

	always_comb begin
		if (sum > SUM_HI) begin
			pend_sat = chsc_pkg::PEND_W'(SUM_HI);
		end else if (sum < SUM_LO) begin
			pend_sat = chsc_pkg::PEND_W'(SUM_LO);
		end else begin
			pend_sat = chsc_pkg::PEND_W'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hand_q  <= '0;
			pend_q  <= '0;
			dst_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (valid_s1) begin
						if (in_init) begin
							dst_q <= item_s1.dst_now;
						end else if (dst_flip) begin
							dst_q  <= item_s1.dst_now;
							pend_q <= pend_sat;
						end
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					state_q <= S_FIX;
				end
				S_FIX: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					if (check_eff && move_eff) begin
						hand_q <= pos_wrapped[chsc_pkg::REV_W-1:0];
						if (!w_init) begin
							pend_q <= pend_sat;
						end
					end
					state_q <= w_init ? S_IDLE : S_STEP1;
				end
				S_STEP1: begin
					pend_q  <= pend_sat;
					state_q <= S_BTN;
				end
				S_BTN: begin
					if (btn_hit) begin
						pend_q <= pend_sat;
					end
					state_q <= S_STEP2;
				end
				S_STEP2: begin
					if (!full) begin
						if (btn_hit) begin
							pend_q <= pend_sat;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			work_q   <= item_s1;
			target_q <= product[chsc_pkg::PROD_W-1:chsc_pkg::FRAC_W];
		end
		if (state_q == S_DIFF) begin
			diff_q <= chsc_pkg::DIFF_W'(target_q) - chsc_pkg::DIFF_W'(hand_q);
		end
		if (state_q == S_FIX) begin
			if (diff_q[chsc_pkg::DIFF_W-1]) begin
				diff_q <= diff_q + chsc_pkg::DIFF_W'(cfg.rev_steps);
				pos_q  <= chsc_pkg::POS_W'(target_q) + rev_pos;
			end else begin
				pos_q  <= chsc_pkg::POS_W'(target_q);
			end
		end
		if (state_q == S_STEP1) begin
			s1_kind_q <= step_now;
		end
	end

	assign push      = (state_q == S_STEP2) && !full;
	assign plan.s1   = s1_kind_q;
	assign plan.has2 = btn_hit;
	assign plan.s2   = btn_hit ? step_now : chsc_pkg::STEP_OFF;
	assign plan.spd2 = btn_spd;

endmodule

`default_nettype wire

[hdl/chsc_queue.sv]
// chsc_queue: small FIFO of step plans between the front and back ends.
// Depends on chsc_pkg.
`default_nettype none

module chsc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire chsc_pkg::plan_t push_data,
	output logic                 full,
	input  wire logic            pop,
	output logic                 empty,
	output chsc_pkg::plan_t      head
);

	localparam int AW = (chsc_pkg::QUEUE_DEPTH > 1) ? $clog2(chsc_pkg::QUEUE_DEPTH) : 1;

	chsc_pkg::plan_t mem_q [chsc_pkg::QUEUE_DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [AW:0]     cnt_q;

	assign full  = (cnt_q == (AW + 1)'(chsc_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// depth is a power of two, pointers wrap on their own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/chsc_back.sv]
// chsc_back: plays queued step plans out as coil nibbles, one result per cycle unless stalled,
// through a registered output stage. Depends on chsc_pkg.
`default_nettype none

module chsc_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire chsc_pkg::cfg_t  cfg,
	input  wire chsc_pkg::plan_t head,
	input  wire logic            empty,
	output logic                 pop,
	output chsc_pkg::result_t    result,
	output logic                 result_valid,
	input  wire logic            result_stall
);

	chsc_pkg::plan_t                plan_q;
	logic                           busy_q;
	logic                           sec_q;
	logic [chsc_pkg::PHASE_W-1:0]   cnt_q;
	logic                           valid_q;
	chsc_pkg::result_t              result_q;

	logic [chsc_pkg::PHASE_W-1:0]   n_last;
	chsc_pkg::step_t                cur_step;
	logic [chsc_pkg::SPD_W-1:0]     cur_spd;
	logic [chsc_pkg::PHASE_W-1:0]   idx;
	logic [chsc_pkg::NIBBLE_W-1:0]  nib;
	logic                           step_end;
	logic                           final_res;
	logic                           emit;
	chsc_pkg::result_t              next_res;

	// phase count 0 plays one phase, anything above the maximum plays the maximum
	always_comb begin
		if (cfg.phase_count == '0) begin
			n_last = '0;
		end else if (cfg.phase_count > chsc_pkg::PCNT_W'(chsc_pkg::MAX_PHASES)) begin
			n_last = chsc_pkg::PHASE_W'(chsc_pkg::MAX_PHASES - 1);
		end else begin
			n_last = chsc_pkg::PHASE_W'(cfg.phase_count - 1'b1);
		end
	end

	assign cur_step  = sec_q ? plan_q.s2 : plan_q.s1;
	assign cur_spd   = sec_q ? plan_q.spd2 : chsc_pkg::SPD_NORMAL;
	assign idx       = (cur_step == chsc_pkg::STEP_CCW) ? (n_last - cnt_q) : cnt_q;
	assign nib       = cfg.pattern[{idx, 2'b00} +: chsc_pkg::NIBBLE_W];
	assign step_end  = (cur_step == chsc_pkg::STEP_OFF) || (cnt_q == n_last);
	assign final_res = step_end && (sec_q || !plan_q.has2);

	assign emit = busy_q && (!valid_q || !result_stall);
	assign pop  = !empty && (!busy_q || (emit && final_res));

	always_comb begin
		next_res.coils       = (cur_step == chsc_pkg::STEP_OFF) ? '0 : nib;
		next_res.direction   = (cur_step == chsc_pkg::STEP_CCW);
		next_res.motor_off   = (cur_step == chsc_pkg::STEP_OFF);
		next_res.speed_class = cur_spd;
		next_res.last        = final_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			sec_q   <= 1'b0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				busy_q <= 1'b1;
				sec_q  <= 1'b0;
				cnt_q  <= '0;
			end else if (emit) begin
				if (final_res) begin
					busy_q <= 1'b0;
				end else if (step_end) begin
					sec_q <= 1'b1;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			plan_q <= head;
		end
		if (emit) begin
			result_q <= next_res;
		end
	end

	assign result       = result_q;
	assign result_valid = valid_q;

endmodule

`default_nettype wire

[hdl/clock_hand_stepper_controller.sv]
// clock_hand_stepper_controller: top level; configuration registers, front end,
// plan queue and back end. Depends on chsc_pkg, chsc_front, chsc_queue, chsc_back.
//
//   port group   dir   flow control        contents
//   item         in    item_valid/stall    chsc_pkg::item_t, one loop pass
//   result       out   result_valid/stall  chsc_pkg::result_t, one coil nibble
//   cfg          in    cfg_we              cfg_index selects, cfg_data
//
// Front end: an update sequencer around one saturating adder, states idle, diff, fix,
// move, step1, btn, step2 (init ends at move); a request waits in an input register.
// Back end: one result per cycle unless stalled, 1 to 2*MAX_PHASES results per pass.
// A 4-deep plan queue lets the two ends stall independently.
// Reset clears control state and loads config defaults at once; no clearing pass.
`default_nettype none

module clock_hand_stepper_controller (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire chsc_pkg::item_t                    item,
	input  wire logic                               item_valid,
	output logic                                    item_stall,
	output chsc_pkg::result_t                       result,
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	input  wire logic                               cfg_we,
	input  wire logic [chsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [chsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	chsc_pkg::cfg_t  cfg_q;
	chsc_pkg::plan_t push_plan;
	chsc_pkg::plan_t head_plan;
	logic            push;
	logic            full;
	logic            pop;
	logic            empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rev_steps   <= chsc_pkg::RST_REV_STEPS;
			cfg_q.steps_per_s <= chsc_pkg::RST_STEPS_PER_S;
			cfg_q.pattern     <= chsc_pkg::RST_PATTERN;
			cfg_q.phase_count <= chsc_pkg::RST_PHASE_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				chsc_pkg::CFG_REV_STEPS:
					cfg_q.rev_steps   <= cfg_data[chsc_pkg::REV_W-1:0];
				chsc_pkg::CFG_STEPS_PER_S:
					cfg_q.steps_per_s <= cfg_data[chsc_pkg::SPS_W-1:0];
				chsc_pkg::CFG_PATTERN:
					cfg_q.pattern     <= cfg_data[chsc_pkg::PATTERN_W-1:0];
				chsc_pkg::CFG_PHASE_COUNT:
					cfg_q.phase_count <= cfg_data[chsc_pkg::PCNT_W-1:0];
				default: ;
			endcase
		end
	end

	chsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (item),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.plan       (push_plan),
		.push       (push),
		.full       (full)
	);

	chsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_plan),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head_plan)
	);

	chsc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head_plan),
		.empty        (empty),
		.pop          (pop),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

`default_nettype wire
